[rtl/core/lbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink controller package
// Command codes, LED modes, field widths and the control and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int PERIOD_W    = 16;   // period_ticks field
   localparam int HALF_W      = 15;   // half period counters
   localparam int COUNT_IN_W  = 16;   // blink_count field
   localparam int INDEX_W     = 2;    // led_index field
   localparam int OUT_LEDS    = 4;    // LEDs shown on the result beat
   localparam int MASK_W      = 4;    // active_high_mask register

   localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;
   localparam logic [MASK_W-1:0]   MASK_DEFAULT = 4'hF;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_SET_ON  = 2'd1,
      CMD_SET_OFF = 2'd2,
      CMD_BLINK   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      MODE_OFF        = 2'd0,
      MODE_ON         = 2'd1,
      MODE_BLINK_DARK = 2'd2,
      MODE_BLINK_LIT  = 2'd3
   } led_mode_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;   // capture the request beat, rewind the LED pointer
      logic apply_cmd;   // apply a set or blink command to the addressed LED
      logic tick_step;   // advance the LED under the pointer by one tick
      logic load_rsp;    // capture pin levels and blinking mask
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_entry;  // pointer sits on the last LED
   } dp_status_type;

endpackage

[rtl/core/lbc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink controller sequencer
// Accepts one request beat at a time, walks the LEDs for a tick, applies a
// set or blink in its apply state, and hands the result to the response register.
// ----------------------------------------------------------------------------
module lbc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_command,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lbc_pkg::ctrl_cmd_type      ctrl,
   input  lbc_pkg::dp_status_type     status
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_APPLY = 4'b0010,
      ST_TICK  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;
   logic      rsp_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      ctrl.load_item = 1'b0;
      ctrl.apply_cmd = 1'b0;
      ctrl.tick_step = 1'b0;
      ctrl.load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ctrl.load_item = 1'b1;
               if (lbc_pkg::command_type'(req_command) == lbc_pkg::CMD_TICK) begin
                  state_in = ST_TICK;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            ctrl.apply_cmd = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_TICK: begin
            ctrl.tick_step = 1'b1;
            if (status.last_entry) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the result until taken, drop it when taken with nothing new behind
   always_comb begin
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/lbc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink controller datapath
// Per-LED mode and blink counters, one shared tick unit that visits the LED
// under the pointer, the polarity register and the response payload.
// ----------------------------------------------------------------------------
module lbc_datapath #(
   parameter int LED_COUNT   = 4,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lbc_pkg::ctrl_cmd_type                 ctrl,
   output lbc_pkg::dp_status_type                status,
   input  logic [1:0]                            req_command,
   input  logic [lbc_pkg::INDEX_W-1:0]           req_led_index,
   input  logic                                  req_start_lit,
   input  logic [lbc_pkg::PERIOD_W-1:0]          req_period_ticks,
   input  logic [lbc_pkg::COUNT_IN_W-1:0]        req_blink_count,
   input  logic                                  csr_write,
   input  logic [lbc_pkg::MASK_W-1:0]            csr_active_high_mask,
   output logic [lbc_pkg::OUT_LEDS-1:0]          rsp_pin_levels,
   output logic [lbc_pkg::OUT_LEDS-1:0]          rsp_blinking_mask
);

   localparam int PTR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_FOREVER = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE     = COUNT_WIDTH'(1);
   localparam logic [lbc_pkg::HALF_W-1:0] HALF_ONE  = lbc_pkg::HALF_W'(1);

   // captured request beat
   lbc_pkg::command_type              cmd_ff;
   logic [lbc_pkg::INDEX_W-1:0]       idx_ff;
   logic                              slit_ff;
   logic [lbc_pkg::PERIOD_W-1:0]      period_ff;
   logic [COUNT_WIDTH-1:0]            count_ff;
   logic [COUNT_WIDTH-1:0]            count_in;
   logic [47:0]                       count_wide;

   logic [PTR_W-1:0]                  ptr_ff, ptr_in;
   logic [lbc_pkg::MASK_W-1:0]        polarity_ff;

   // per-LED state
   lbc_pkg::led_mode_type             mode_ff        [LED_COUNT];
   logic                              starts_lit_ff  [LED_COUNT];
   logic [lbc_pkg::HALF_W-1:0]        reload_ff      [LED_COUNT];
   logic [lbc_pkg::HALF_W-1:0]        left_ff        [LED_COUNT];
   logic [COUNT_WIDTH-1:0]            requested_ff   [LED_COUNT];
   logic [COUNT_WIDTH-1:0]            blinks_left_ff [LED_COUNT];

   logic [lbc_pkg::OUT_LEDS-1:0]      pins_ff, pins_in;
   logic [lbc_pkg::OUT_LEDS-1:0]      blinking_ff, blinking_in;

   // shared unit
   logic [31:0]                       idx_wide;
   logic                              idx_ok;
   logic [PTR_W-1:0]                  idx_ptr;
   logic [PTR_W-1:0]                  sel;
   lbc_pkg::led_mode_type             cur_mode;
   logic                              cur_slit;
   logic [lbc_pkg::HALF_W-1:0]        cur_left;
   logic [lbc_pkg::HALF_W-1:0]        cur_reload;
   logic [COUNT_WIDTH-1:0]            cur_requested;
   logic [COUNT_WIDTH-1:0]            cur_bl;
   logic [COUNT_WIDTH-1:0]            bl_dec;
   logic                              counts;
   logic [lbc_pkg::PERIOD_W-1:0]      eff_period;
   logic [lbc_pkg::HALF_W-1:0]        new_reload;
   logic [COUNT_WIDTH-1:0]            eff_count;

   logic                              mode_we, left_we, bl_we, blink_we;
   lbc_pkg::led_mode_type             mode_in;
   logic [lbc_pkg::HALF_W-1:0]        left_in;
   logic [COUNT_WIDTH-1:0]            bl_in;

   assign count_wide = {32'd0, req_blink_count};
   assign count_in   = count_wide[COUNT_WIDTH-1:0];

   assign idx_wide = 32'(idx_ff);
   assign idx_ok   = idx_wide < 32'(LED_COUNT);
   assign idx_ptr  = idx_wide[PTR_W-1:0];
   assign sel      = ctrl.apply_cmd ? idx_ptr : ptr_ff;

   assign status.last_entry = (ptr_ff == PTR_W'(LED_COUNT - 1));

   assign cur_mode      = mode_ff[sel];
   assign cur_slit      = starts_lit_ff[sel];
   assign cur_left      = left_ff[sel];
   assign cur_reload    = reload_ff[sel];
   assign cur_requested = requested_ff[sel];
   assign cur_bl        = blinks_left_ff[sel];
   assign bl_dec        = cur_bl - COUNT_ONE;
   assign counts        = (cur_requested != COUNT_FOREVER);

   assign eff_period = (period_ff < lbc_pkg::PERIOD_MIN) ? lbc_pkg::PERIOD_MIN : period_ff;
   assign new_reload = eff_period[lbc_pkg::PERIOD_W-1:1];
   assign eff_count  = (count_ff == '0) ? COUNT_ONE : count_ff;

   always_comb begin
      mode_we  = 1'b0;
      left_we  = 1'b0;
      bl_we    = 1'b0;
      blink_we = 1'b0;
      mode_in  = cur_mode;
      left_in  = cur_left;
      bl_in    = bl_dec;
      if (ctrl.apply_cmd && idx_ok) begin
         unique case (cmd_ff)
            lbc_pkg::CMD_SET_ON: begin
               mode_we = 1'b1;
               mode_in = lbc_pkg::MODE_ON;
            end
            lbc_pkg::CMD_SET_OFF: begin
               mode_we = 1'b1;
               mode_in = lbc_pkg::MODE_OFF;
            end
            lbc_pkg::CMD_BLINK: begin
               blink_we = 1'b1;
               mode_we  = 1'b1;
               left_we  = 1'b1;
               bl_we    = 1'b1;
               mode_in  = slit_ff ? lbc_pkg::MODE_BLINK_LIT : lbc_pkg::MODE_BLINK_DARK;
               left_in  = new_reload;
               bl_in    = eff_count;
            end
            lbc_pkg::CMD_TICK: begin
            end
         endcase
      end else if (ctrl.tick_step && (cur_mode == lbc_pkg::MODE_BLINK_LIT ||
                                      cur_mode == lbc_pkg::MODE_BLINK_DARK)) begin
         left_we = 1'b1;
         if (cur_left > HALF_ONE) begin
            left_in = cur_left - HALF_ONE;
         end else begin
            // half period over: reload, toggle, count on return to start level
            left_in = cur_reload;
            mode_we = 1'b1;
            if (cur_mode == lbc_pkg::MODE_BLINK_LIT) begin
               mode_in = lbc_pkg::MODE_BLINK_DARK;
               if (!cur_slit && counts) begin
                  bl_we = 1'b1;
                  if (bl_dec == '0) begin
                     mode_in = lbc_pkg::MODE_ON;
                  end
               end
            end else begin
               mode_in = lbc_pkg::MODE_BLINK_LIT;
               if (cur_slit && counts) begin
                  bl_we = 1'b1;
                  if (bl_dec == '0) begin
                     mode_in = lbc_pkg::MODE_OFF;
                  end
               end
            end
         end
      end
   end

   assign ptr_in = ctrl.load_item ? '0 : (ctrl.tick_step ? ptr_ff + PTR_W'(1) : ptr_ff);

   // result view of the first four LEDs
   for (genvar g = 0; g < lbc_pkg::OUT_LEDS; g++) begin : g_out
      if (g < LED_COUNT) begin : g_led
         logic lit;
         assign lit = (mode_ff[g] == lbc_pkg::MODE_ON) ||
                      (mode_ff[g] == lbc_pkg::MODE_BLINK_LIT);
         assign pins_in[g]     = lit ^ ~polarity_ff[g];
         assign blinking_in[g] = (mode_ff[g] == lbc_pkg::MODE_BLINK_LIT) ||
                                 (mode_ff[g] == lbc_pkg::MODE_BLINK_DARK);
      end else begin : g_none
         assign pins_in[g]     = 1'b0;
         assign blinking_in[g] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= lbc_pkg::MASK_DEFAULT;
         ptr_ff      <= '0;
         for (int i = 0; i < LED_COUNT; i++) begin
            mode_ff[i] <= lbc_pkg::MODE_OFF;
         end
      end else begin
         if (csr_write) begin
            polarity_ff <= csr_active_high_mask;
         end
         ptr_ff <= ptr_in;
         if (mode_we) begin
            mode_ff[sel] <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         cmd_ff    <= lbc_pkg::command_type'(req_command);
         idx_ff    <= req_led_index;
         slit_ff   <= req_start_lit;
         period_ff <= req_period_ticks;
         count_ff  <= count_in;
      end
      if (blink_we) begin
         starts_lit_ff[sel] <= slit_ff;
         reload_ff[sel]     <= new_reload;
         requested_ff[sel]  <= eff_count;
      end
      if (left_we) begin
         left_ff[sel] <= left_in;
      end
      if (bl_we) begin
         blinks_left_ff[sel] <= bl_in;
      end
      if (ctrl.load_rsp) begin
         pins_ff     <= pins_in;
         blinking_ff <= blinking_in;
      end
   end

   assign rsp_pin_levels    = pins_ff;
   assign rsp_blinking_mask = blinking_ff;

endmodule

[rtl/core/led_blink_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink controller
// Keeps a bank of LEDs steady on, steady off or blinking, and answers every
// command beat with the pin levels and the blinking mask.
// ----------------------------------------------------------------------------
// Each accepted request beat yields exactly one response beat. A set-on,
// set-off or blink command is captured, applied and loaded into the
// response register; a tick is captured, then one shared tick unit visits
// the LEDs one per cycle, then the response register is loaded. A finished
// response waits in its own register, so the next request
// is taken while the previous response is still stalled; the block only holds
// off a result of its own when the register is still occupied. The polarity
// register is written through the csr_ port, which is always ready; write it
// only while no request is in flight. Pin bit i is driven high to light LED i
// when active_high_mask bit i is set, low when it is clear. Only LEDs 0 to 3
// appear on the response; higher LEDs are kept but not shown.
// ----------------------------------------------------------------------------
module led_blink_controller #(
   parameter int LED_COUNT   = 4,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [lbc_pkg::INDEX_W-1:0]       req_led_index,
   input  logic                              req_start_lit,
   input  logic [lbc_pkg::PERIOD_W-1:0]      req_period_ticks,
   input  logic [lbc_pkg::COUNT_IN_W-1:0]    req_blink_count,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lbc_pkg::OUT_LEDS-1:0]      rsp_pin_levels,
   output logic [lbc_pkg::OUT_LEDS-1:0]      rsp_blinking_mask,
   // polarity register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbc_pkg::MASK_W-1:0]        csr_active_high_mask
);

   lbc_pkg::ctrl_cmd_type  ctrl;
   lbc_pkg::dp_status_type status;
   logic                   csr_write;

   // the register takes a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sequencer: handshakes and the order of the work
   lbc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .ctrl        (ctrl),
      .status      (status)
   );

   // per-LED state, tick unit and response payload
   lbc_datapath #(
      .LED_COUNT   (LED_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (ctrl),
      .status               (status),
      .req_command          (req_command),
      .req_led_index        (req_led_index),
      .req_start_lit        (req_start_lit),
      .req_period_ticks     (req_period_ticks),
      .req_blink_count      (req_blink_count),
      .csr_write            (csr_write),
      .csr_active_high_mask (csr_active_high_mask),
      .rsp_pin_levels       (rsp_pin_levels),
      .rsp_blinking_mask    (rsp_blinking_mask)
   );

`ifndef ASSERT_OFF
   // one beat in flight: an accepted beat holds off the next one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a command is in flight");

   // a new response appears only at the end of a command's work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised with no command in flight");

   // a fresh response beat never overwrites a stalled one
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && ctrl.load_rsp |-> 1'b0)
      else $error("response register loaded while stalled");
`endif

endmodule

[sim/led_blink_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink controller regression bench
// Drives command beats into the controller and checks each response beat
// against an in-bench model of the LED bank. A directed table covers the
// extremes first. Random traffic follows under three stall regimes and
// several polarity settings.
// ----------------------------------------------------------------------------
module led_blink_controller_tb;

   localparam logic [15:0] BLINK_FOREVER = 16'hFFFF;
   localparam int          LED_TOTAL     = 4;
   localparam int          CHUNK_BEATS   = 210;

   // One command beat. A directed row may carry its response typed in.
   typedef struct packed {
      lbc_pkg::command_type command;
      logic [1:0]           led_index;
      logic                 start_lit;
      logic [15:0]          period_ticks;
      logic [15:0]          blink_count;
      logic                 has_known;
      logic [3:0]           known_pins;
      logic [3:0]           known_blinking;
   } led_request_type;

   typedef struct packed {
      logic [3:0] pins;
      logic [3:0] blinking;
   } led_view_type;

   // Opening checks: the response values after reset, for steady set-on and
   // set-off, and for a fresh blink with a minimum period and zero count, are
   // typed in. The rest come from the bench model: a period of one, the
   // widest period with the forever count, blinks abandoned by set
   // commands, and a two-blink run.
   localparam led_request_type DIRECTED_ROWS [0:24] = '{
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b1, 4'h0, 4'h0},
      '{lbc_pkg::CMD_SET_ON,  2'd0, 1'b0, 16'h0000, 16'h0000, 1'b1, 4'h1, 4'h0},
      '{lbc_pkg::CMD_SET_ON,  2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 4'h9, 4'h0},
      '{lbc_pkg::CMD_SET_OFF, 2'd0, 1'b0, 16'h0000, 16'h0000, 1'b1, 4'h8, 4'h0},
      '{lbc_pkg::CMD_SET_OFF, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 4'h0, 4'h0},
      '{lbc_pkg::CMD_BLINK,   2'd1, 1'b1, 16'h0000, 16'h0000, 1'b1, 4'h2, 4'h2},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_BLINK,   2'd2, 1'b0, 16'h0001, 16'h0001, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_BLINK,   2'd0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_BLINK,   2'd3, 1'b0, 16'h0003, 16'hFFFF, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_SET_OFF, 2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_SET_ON,  2'd3, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_BLINK,   2'd1, 1'b1, 16'h0004, 16'h0002, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_TICK,    2'd0, 1'b0, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_BLINK,   2'd2, 1'b0, 16'h8000, 16'hFFFE, 1'b0, 4'h0, 4'h0},
      '{lbc_pkg::CMD_SET_ON,  2'd2, 1'b1, 16'h7FFF, 16'h0001, 1'b0, 4'h0, 4'h0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = lbc_pkg::CMD_TICK;
   logic [1:0]  req_led_index = 2'd0;
   logic        req_start_lit = 1'b0;
   logic [15:0] req_period_ticks = 16'd0;
   logic [15:0] req_blink_count = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_pin_levels;
   logic [3:0]  rsp_blinking_mask;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_active_high_mask = lbc_pkg::MASK_DEFAULT;

   // Bench copy of the LED bank and of the polarity register
   lbc_pkg::led_mode_type mode_q        [LED_TOTAL];
   logic                  starts_lit_q  [LED_TOTAL];
   logic [14:0]           half_reload_q [LED_TOTAL];
   logic [14:0]           half_left_q   [LED_TOTAL];
   logic [15:0]           blinks_req_q  [LED_TOTAL];
   logic [15:0]           blinks_left_q [LED_TOTAL];
   logic [3:0]            polarity_q;

   led_request_type req_backlog[$];   // beats still to be offered
   led_request_type req_on_wire;      // beat currently presented
   led_view_type    views_due[$];     // responses owed by the block, oldest first

   int unsigned send_gap_pct;      // chance the sender idles on a cycle
   int unsigned rsp_hold_pct;      // chance the receiver stalls on a cycle
   int          failures = 0;

   led_blink_controller #(
      .LED_COUNT   (LED_TOTAL),
      .COUNT_WIDTH (16)
   ) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_led_index        (req_led_index),
      .req_start_lit        (req_start_lit),
      .req_period_ticks     (req_period_ticks),
      .req_blink_count      (req_blink_count),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pin_levels       (rsp_pin_levels),
      .rsp_blinking_mask    (rsp_blinking_mask),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_active_high_mask (csr_active_high_mask)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Advance one LED by a single tick. Toggle on an expired half period and
   // count a blink on the return to the starting level, unless the blink
   // runs forever.
   function automatic void tick_led(int i);
      logic counts;
      if (mode_q[i] != lbc_pkg::MODE_BLINK_DARK && mode_q[i] != lbc_pkg::MODE_BLINK_LIT)
         return;
      if (half_left_q[i] > 15'd1) begin
         half_left_q[i] = half_left_q[i] - 15'd1;
         return;
      end
      half_left_q[i] = half_reload_q[i];
      counts = (blinks_req_q[i] != BLINK_FOREVER);
      if (mode_q[i] == lbc_pkg::MODE_BLINK_LIT) begin
         if (!starts_lit_q[i] && counts) begin
            blinks_left_q[i] = blinks_left_q[i] - 16'd1;
            if (blinks_left_q[i] == 16'd0) begin
               mode_q[i] = lbc_pkg::MODE_ON;
               return;
            end
         end
         mode_q[i] = lbc_pkg::MODE_BLINK_DARK;
      end else begin
         if (starts_lit_q[i] && counts) begin
            blinks_left_q[i] = blinks_left_q[i] - 16'd1;
            if (blinks_left_q[i] == 16'd0) begin
               mode_q[i] = lbc_pkg::MODE_OFF;
               return;
            end
         end
         mode_q[i] = lbc_pkg::MODE_BLINK_LIT;
      end
   endfunction

   // Apply one command beat to the bank and return the levels it answers with
   function automatic led_view_type step_leds(led_request_type r);
      led_view_type v;
      logic [15:0]  per;
      logic [15:0]  cnt;
      logic         lit;
      case (r.command)
         lbc_pkg::CMD_TICK: begin
            for (int i = 0; i < LED_TOTAL; i++)
               tick_led(i);
         end
         lbc_pkg::CMD_SET_ON:  mode_q[r.led_index] = lbc_pkg::MODE_ON;
         lbc_pkg::CMD_SET_OFF: mode_q[r.led_index] = lbc_pkg::MODE_OFF;
         default: begin
            per = (r.period_ticks < lbc_pkg::PERIOD_MIN) ? lbc_pkg::PERIOD_MIN
                                                         : r.period_ticks;
            cnt = (r.blink_count == 16'd0) ? 16'd1 : r.blink_count;
            starts_lit_q[r.led_index]  = r.start_lit;
            mode_q[r.led_index]        = r.start_lit ? lbc_pkg::MODE_BLINK_LIT
                                                     : lbc_pkg::MODE_BLINK_DARK;
            half_reload_q[r.led_index] = per[15:1];
            half_left_q[r.led_index]   = per[15:1];
            blinks_req_q[r.led_index]  = cnt;
            blinks_left_q[r.led_index] = cnt;
         end
      endcase
      for (int i = 0; i < LED_TOTAL; i++) begin
         lit = (mode_q[i] == lbc_pkg::MODE_ON || mode_q[i] == lbc_pkg::MODE_BLINK_LIT);
         v.pins[i]     = polarity_q[i] ? lit : !lit;
         v.blinking[i] = (mode_q[i] == lbc_pkg::MODE_BLINK_DARK ||
                          mode_q[i] == lbc_pkg::MODE_BLINK_LIT);
      end
      return v;
   endfunction

   // Mostly ticks and short blinks so that blinks run to completion often;
   // the rest is set commands that cut blinks short, and wide values.
   function automatic led_request_type random_request();
      led_request_type r;
      int unsigned     pick;
      r = '0;
      pick = $urandom_range(99);
      if (pick < 55)      r.command = lbc_pkg::CMD_TICK;
      else if (pick < 75) r.command = lbc_pkg::CMD_BLINK;
      else if (pick < 87) r.command = lbc_pkg::CMD_SET_ON;
      else                r.command = lbc_pkg::CMD_SET_OFF;
      r.led_index    = 2'($urandom_range(3));
      r.start_lit    = 1'($urandom_range(1));
      r.period_ticks = 16'($urandom);
      r.blink_count  = 16'($urandom);
      if (r.command == lbc_pkg::CMD_BLINK) begin
         pick = $urandom_range(9);
         if (pick < 7)      r.period_ticks = 16'($urandom_range(7));
         else if (pick < 9) r.period_ticks = 16'($urandom_range(40));
         pick = $urandom_range(9);
         if (pick < 6)       r.blink_count = 16'($urandom_range(4));
         else if (pick < 8)  r.blink_count = 16'($urandom_range(12));
         else if (pick == 8) r.blink_count = BLINK_FOREVER;
      end
      return r;
   endfunction

   // Offer every beat in the backlog. Record the response owed on each
   // accepted beat, then present the next one or drop valid.
   task automatic drive_backlog();
      logic on_wire;
      on_wire = 1'b0;
      do begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            if (req_on_wire.has_known) begin
               void'(step_leds(req_on_wire));
               views_due.push_back({req_on_wire.known_pins, req_on_wire.known_blinking});
            end else begin
               views_due.push_back(step_leds(req_on_wire));
            end
            on_wire = 1'b0;
         end
         // a stalled beat holds its payload
         if (!on_wire) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_on_wire      = req_backlog.pop_front();
               req_command      <= req_on_wire.command;
               req_led_index    <= req_on_wire.led_index;
               req_start_lit    <= req_on_wire.start_lit;
               req_period_ticks <= req_on_wire.period_ticks;
               req_blink_count  <= req_on_wire.blink_count;
               req_valid        <= 1'b1;
               on_wire = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end while (on_wire || req_backlog.size() != 0);
   endtask

   task automatic wait_drained();
      while (views_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_polarity(logic [3:0] mask);
      @(posedge clock);
      csr_active_high_mask <= mask;
      csr_valid            <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      polarity_q = mask;
   endtask

   // Response side: check each beat taken, then stall at random for the next
   always @(posedge clock) begin : rsp_check
      led_view_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (views_due.size() == 0) begin
               $error("response beat with none outstanding: pins %0h blinking %0h",
                      rsp_pin_levels, rsp_blinking_mask);
               failures++;
            end else begin
               due = views_due.pop_front();
               if (rsp_pin_levels !== due.pins) begin
                  $error("pin_levels: expected %0h, got %0h", due.pins, rsp_pin_levels);
                  failures++;
               end
               if (rsp_blinking_mask !== due.blinking) begin
                  $error("blinking_mask: expected %0h, got %0h",
                         due.blinking, rsp_blinking_mask);
                  failures++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   // Stimulus: directed table, then random chunks per stall regime, each
   // chunk under its own polarity with both extremes in every regime.
   initial begin
      logic [3:0] mask;
      polarity_q = lbc_pkg::MASK_DEFAULT;
      for (int i = 0; i < LED_TOTAL; i++) begin
         mode_q[i]        = lbc_pkg::MODE_OFF;
         starts_lit_q[i]  = 1'b0;
         half_reload_q[i] = '0;
         half_left_q[i]   = '0;
         blinks_req_q[i]  = '0;
         blinks_left_q[i] = '0;
      end
      send_gap_pct = 17;
      rsp_hold_pct = 76;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[k])
         req_backlog.push_back(DIRECTED_ROWS[k]);
      drive_backlog();

      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin send_gap_pct = 17; rsp_hold_pct = 76; end
            1: begin send_gap_pct = 76; rsp_hold_pct = 17; end
            default: begin send_gap_pct = 0; rsp_hold_pct = 0; end
         endcase
         for (int chunk = 0; chunk < 3; chunk++) begin
            case (chunk)
               0: mask = 4'h0;
               1: mask = 4'($urandom_range(15));
               default: mask = 4'hF;
            endcase
            // the block must be idle before the polarity changes
            wait_drained();
            write_polarity(mask);
            repeat (CHUNK_BEATS)
               req_backlog.push_back(random_request());
            drive_backlog();
         end
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Hang guard, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
